// ===== sv/fifo_queue_with_search_assert.svh =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search assertion macros
// Shared assertion forms for the queue logic.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH

// same-cycle implication
`define FQS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fqs: assertion failed");

// next-cycle implication
`define FQS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fqs: assertion failed");

`endif

// ===== sv/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqs_pkg
// Constants, types and helpers shared by the queue-with-search block.
// ----------------------------------------------------------------------------
package fqs_pkg;

   localparam int DEPTH         = 16;
   localparam int IDX_W         = $clog2(DEPTH);
   localparam int CNT_W         = $clog2(DEPTH + 1);
   localparam int DATA_W        = 32;
   localparam int ACT_W         = 2;
   localparam int ENTRY_COUNT_W = 5;

   localparam logic signed [DATA_W-1:0] NONE_VALUE = '1;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH = 2'd0,
      ACT_POP  = 2'd1,
      ACT_FIND = 2'd2,
      ACT_NOP  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD_RD,
      ST_HEAD_WB,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic                     rd_en;
      logic [IDX_W-1:0]         rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      logic                     hit;
      logic                     empty_error;
      logic                     full_error;
      logic [CNT_W-1:0]         entry_count;
      logic signed [DATA_W-1:0] head_value;
      logic signed [DATA_W-1:0] tail_value;
   } rsp_type;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      if (idx == IDX_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + IDX_W'(1);
      end
      return nxt;
   endfunction

endpackage

// ===== sv/fqs_store.sv =====
// ----------------------------------------------------------------------------
// fqs_store
// Circular entry storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fqs_store import fqs_pkg::*; (
   input  logic                     clock,
   input  mem_req_type              mem_req,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] entry_mem_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entry_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= entry_mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fqs_ctrl
// Sequencer, queue pointers and the single compare unit used by find.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_search_assert.svh"

module fqs_ctrl import fqs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_take,
   input  logic [ACT_W-1:0]         req_action,
   input  logic signed [DATA_W-1:0] req_data_in,
   output logic                     ready,
   input  logic                     out_free,
   output logic                     done_valid,
   output rsp_type                  done_rsp,
   output mem_req_type              mem_req,
   input  logic signed [DATA_W-1:0] rd_data
);

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [DATA_W-1:0] head_val_ff, head_val_in;
   logic signed [DATA_W-1:0] tail_val_ff, tail_val_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]         issue_left_ff, issue_left_in;
   logic                     cmp_valid_ff, cmp_valid_in;
   logic signed [DATA_W-1:0] res_data_ff, res_data_in;
   logic                     res_hit_ff, res_hit_in;
   logic                     res_empty_ff, res_empty_in;
   logic                     res_full_ff, res_full_in;

   logic is_empty;
   logic is_full;
   logic scan_issue;
   logic match;
   logic scan_last;
   logic push_ok;
   logic [CNT_W-1:0] count_inc;

   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign scan_issue = (issue_left_ff != '0);
   // compare unit: one stored entry per cycle against the key
   assign match      = cmp_valid_ff && (rd_data == key_ff);
   assign scan_last  = cmp_valid_ff && !scan_issue;
   assign push_ok    = req_take && (action_type'(req_action) == ACT_PUSH) && !is_full;
   assign count_inc  = count_ff + CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (action_type'(req_action))
                  ACT_PUSH: state_in = ST_DONE;
                  ACT_POP:  state_in = is_empty ? ST_DONE : ST_HEAD_RD;
                  ACT_FIND: state_in = is_empty ? ST_DONE : ST_SCAN;
                  ACT_NOP:  state_in = ST_DONE;
               endcase
            end
         end
         ST_HEAD_RD: state_in = ST_HEAD_WB;
         ST_HEAD_WB: state_in = ST_DONE;
         ST_SCAN: begin
            if (match || scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      head_val_in     = head_val_ff;
      tail_val_in     = tail_val_ff;
      key_in          = key_ff;
      scan_idx_in     = scan_idx_ff;
      issue_left_in   = issue_left_ff;
      cmp_valid_in    = cmp_valid_ff;
      res_data_in     = res_data_ff;
      res_hit_in      = res_hit_ff;
      res_empty_in    = res_empty_ff;
      res_full_in     = res_full_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = tail_ff;
      mem_req.wr_data = req_data_in;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_data_in  = NONE_VALUE;
               res_hit_in   = 1'b0;
               res_empty_in = 1'b0;
               res_full_in  = 1'b0;
               unique case (action_type'(req_action))
                  ACT_PUSH: begin
                     if (is_full) begin
                        res_full_in = 1'b1;
                     end else begin
                        mem_req.wr_en = 1'b1;
                        tail_in       = next_idx(tail_ff);
                        count_in      = count_ff + CNT_W'(1);
                        tail_val_in   = req_data_in;
                        if (is_empty) begin
                           head_val_in = req_data_in;
                        end
                     end
                  end
                  ACT_POP: begin
                     if (is_empty) begin
                        res_empty_in = 1'b1;
                     end else begin
                        res_data_in = head_val_ff;
                        res_hit_in  = 1'b1;
                        head_in     = next_idx(head_ff);
                        count_in    = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_FIND: begin
                     if (is_empty) begin
                        res_empty_in = 1'b1;
                     end else begin
                        key_in        = req_data_in;
                        scan_idx_in   = head_ff;
                        issue_left_in = count_ff;
                        cmp_valid_in  = 1'b0;
                     end
                  end
                  ACT_NOP: begin
                  end
               endcase
            end
         end
         ST_HEAD_RD: begin
            // head pointer already advanced; fetch the new oldest entry
            mem_req.rd_en = 1'b1;
         end
         ST_HEAD_WB: begin
            head_val_in = rd_data;
         end
         ST_SCAN: begin
            mem_req.rd_en   = scan_issue;
            mem_req.rd_addr = scan_idx_ff;
            cmp_valid_in    = scan_issue;
            if (scan_issue) begin
               scan_idx_in   = next_idx(scan_idx_ff);
               issue_left_in = issue_left_ff - CNT_W'(1);
            end
            if (match) begin
               res_data_in = key_ff;
               res_hit_in  = 1'b1;
            end
         end
         ST_DONE: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         issue_left_ff <= '0;
         cmp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         issue_left_ff <= issue_left_in;
         cmp_valid_ff  <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_val_ff  <= head_val_in;
      tail_val_ff  <= tail_val_in;
      key_ff       <= key_in;
      scan_idx_ff  <= scan_idx_in;
      res_data_ff  <= res_data_in;
      res_hit_ff   <= res_hit_in;
      res_empty_ff <= res_empty_in;
      res_full_ff  <= res_full_in;
   end

   assign ready      = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);

   always_comb begin
      done_rsp.data_out    = res_data_ff;
      done_rsp.hit         = res_hit_ff;
      done_rsp.empty_error = res_empty_ff;
      done_rsp.full_error  = res_full_ff;
      done_rsp.entry_count = count_ff;
      done_rsp.head_value  = is_empty ? NONE_VALUE : head_val_ff;
      done_rsp.tail_value  = is_empty ? NONE_VALUE : tail_val_ff;
   end

   `FQS_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `FQS_ASSERT_IMPL(a_empty_ptrs, clock, reset, is_empty, head_ff == tail_ff)
   `FQS_ASSERT_IMPL(a_take_idle, clock, reset, req_take, state_ff == ST_IDLE)
   `FQS_ASSERT_IMPL(a_scan_bound, clock, reset, state_ff == ST_SCAN, issue_left_ff <= count_ff)
   `FQS_ASSERT_NEXT(a_push_count, clock, reset, push_ok, count_ff == $past(count_inc))

endmodule

// ===== sv/fifo_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// FIFO of signed 32-bit values with push, pop and content find.
//
// Request channel (req_valid/req_stall): req_action selects push, pop or
// find; req_data_in is the value pushed or searched for. One transaction in
// gives exactly one transaction out on the rsp_ channel.
// Flow: push, the unused action and pop or find on an empty queue go from
// idle straight to done; pop passes a head read and a head write-back state;
// find compares entries in order until a match, at most the stored count (DEPTH max).
// The find scan uses the single compare unit stepping one stored entry
// per cycle through the one read port of the entry memory. req_stall is high
// while a transaction is in progress.
// Results go to an output register, so the sequencer frees up once a result
// moves there; while the receiver stalls a held result, the next finished
// result waits in the sequencer and req_stall stays high.
// Reset empties the queue (count, head and tail pointers cleared); memory
// contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_queue_with_search import fqs_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ACT_W-1:0]                req_action,
   input  logic signed [DATA_W-1:0]        req_data_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [DATA_W-1:0]        rsp_data_out,
   output logic                            rsp_hit,
   output logic                            rsp_empty_error,
   output logic                            rsp_full_error,
   output logic [ENTRY_COUNT_W-1:0]        rsp_entry_count,
   output logic signed [DATA_W-1:0]        rsp_head_value,
   output logic signed [DATA_W-1:0]        rsp_tail_value
);

   logic                     ready;
   logic                     req_take;
   logic                     out_free;
   logic                     done_valid;
   rsp_type                  done_rsp;
   mem_req_type              mem_req;
   logic signed [DATA_W-1:0] rd_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign req_stall = !ready;
   assign req_take  = req_valid && ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   fqs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_take    (req_take),
      .req_action  (req_action),
      .req_data_in (req_data_in),
      .ready       (ready),
      .out_free    (out_free),
      .done_valid  (done_valid),
      .done_rsp    (done_rsp),
      .mem_req     (mem_req),
      .rd_data     (rd_data)
   );

   fqs_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = done_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = rsp_ff.data_out;
   assign rsp_hit         = rsp_ff.hit;
   assign rsp_empty_error = rsp_ff.empty_error;
   assign rsp_full_error  = rsp_ff.full_error;
   assign rsp_entry_count = ENTRY_COUNT_W'(rsp_ff.entry_count);
   assign rsp_head_value  = rsp_ff.head_value;
   assign rsp_tail_value  = rsp_ff.tail_value;

endmodule
